[rtl/core/orbit_camera_eye_position_top_assert.svh]
// assertion macros shared by the checker
`ifndef ORBIT_CAMERA_EYE_POSITION_TOP_ASSERT_SVH
`define ORBIT_CAMERA_EYE_POSITION_TOP_ASSERT_SVH

// property checked only outside reset
`define OCEP_ASSERT_GATED(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every edge, reset included
`define OCEP_ASSERT_RAW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/ocep_pkg.sv]
`timescale 1ns / 1ps

package ocep_pkg;

  localparam int LEN_W   = 32;
  localparam int ANG_W   = 16;
  localparam int CW      = 34;   // cordic x, y, z width
  localparam int PROD_W  = 65;   // 33 x 32 signed product
  localparam int Q_DEPTH = 2;

  localparam logic [ANG_W-1:0]    ANGLE_RST = 16'd8192;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic signed [LEN_W-1:0] radius;
    logic [ANG_W-1:0]        polar;
    logic [ANG_W-1:0]        azimuth;
    logic signed [LEN_W-1:0] cx;
    logic signed [LEN_W-1:0] cz;
  } snap_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic                 flip;
    logic signed [CW-1:0] z;
  } fold_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } back_state_t;

  typedef enum logic [1:0] {
    MS_RSIN,
    MS_EYEY,
    MS_EYEX,
    MS_EYEZ
  } mul_sel_t;

  // atan(2^-i), 2^32 units per turn
  function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/ocep_front.sv]
`timescale 1ns / 1ps

module ocep_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  q_full,
  input  logic                  in_req_type,
  input  logic signed [31:0]    in_delta_radius,
  input  logic signed [15:0]    in_delta_polar,
  input  logic signed [15:0]    in_delta_azimuth,
  input  logic signed [31:0]    in_delta_center_x,
  input  logic signed [31:0]    in_delta_center_z,
  output logic                  q_push,
  output ocep_pkg::snap_t       q_data
);

  localparam int RADIUS_RST_I = 30 << FRAC_BITS;
  localparam logic signed [ocep_pkg::LEN_W-1:0] RADIUS_RST =
    ocep_pkg::LEN_W'(RADIUS_RST_I);

  logic signed [ocep_pkg::LEN_W-1:0] radius_r, radius_nxt;
  logic [ocep_pkg::ANG_W-1:0]        polar_r, polar_nxt;
  logic [ocep_pkg::ANG_W-1:0]        azimuth_r, azimuth_nxt;
  logic signed [ocep_pkg::LEN_W-1:0] cx_r, cx_nxt;
  logic signed [ocep_pkg::LEN_W-1:0] cz_r, cz_nxt;
  logic                              accept;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
    return s[31:0];
  endfunction

  assign accept = in_push && !q_full;

  always_comb begin
    radius_nxt  = radius_r;
    polar_nxt   = polar_r;
    azimuth_nxt = azimuth_r;
    cx_nxt      = cx_r;
    cz_nxt      = cz_r;
    if (!in_req_type) begin
      radius_nxt  = sat_add(radius_r, in_delta_radius);
      polar_nxt   = polar_r + in_delta_polar;
      azimuth_nxt = azimuth_r + in_delta_azimuth;
    end else begin
      cx_nxt = sat_add(cx_r, in_delta_center_x);
      cz_nxt = sat_add(cz_r, in_delta_center_z);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RADIUS_RST;
      polar_r   <= ocep_pkg::ANGLE_RST;
      azimuth_r <= ocep_pkg::ANGLE_RST;
      cx_r      <= '0;
      cz_r      <= '0;
    end else if (accept) begin
      radius_r  <= radius_nxt;
      polar_r   <= polar_nxt;
      azimuth_r <= azimuth_nxt;
      cx_r      <= cx_nxt;
      cz_r      <= cz_nxt;
    end
  end

  // the snapshot carries the state as it stands after this word
  assign q_push         = accept;
  assign q_data.radius  = radius_nxt;
  assign q_data.polar   = polar_nxt;
  assign q_data.azimuth = azimuth_nxt;
  assign q_data.cx      = cx_nxt;
  assign q_data.cz      = cz_nxt;

endmodule

[rtl/core/ocep_fifo.sv]
`timescale 1ns / 1ps

module ocep_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ocep_pkg::snap_t wr_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output ocep_pkg::snap_t rd_data
);

  localparam int PTR_W = $clog2(ocep_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(ocep_pkg::Q_DEPTH + 1);

  ocep_pkg::snap_t  mem_r [ocep_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(ocep_pkg::Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(ocep_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(ocep_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/ocep_back.sv]
`timescale 1ns / 1ps

module ocep_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  ocep_pkg::snap_t     q_data,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output logic signed [31:0]  out_eye_x,
  output logic signed [31:0]  out_eye_y,
  output logic signed [31:0]  out_eye_z
);

  localparam int CW    = ocep_pkg::CW;
  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);
  localparam logic signed [16:0] QTR  = 17'sd16384;
  localparam logic signed [16:0] HALF = 17'sd32768;
  localparam logic signed [ocep_pkg::PROD_W-1:0] RND_HALF = 65'sd536870912;
  localparam logic signed [35:0] SMAX = 36'sd2147483647;
  localparam logic signed [35:0] SMIN = -36'sd2147483648;

  ocep_pkg::back_state_t state_r, state_nxt;
  ocep_pkg::mul_sel_t    sel_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  out_valid_r;
  logic                  load_out;

  logic signed [31:0]    r_r, cx_r, cz_r;
  ocep_pkg::cordic_t     pc_r, ac_r, pc_step, ac_step;
  logic                  pflip_r, aflip_r;
  ocep_pkg::fold_t       pfold, afold;
  logic [31:0]           atn;
  logic signed [CW-1:0]  st_w, ct_w, sp_w, cp_w;

  logic signed [32:0]    mul_a;
  logic signed [31:0]    mul_b;
  logic signed [ocep_pkg::PROD_W-1:0] prod_r, rnd_full;
  logic signed [34:0]    rnd;
  logic signed [32:0]    rs_r;
  logic signed [31:0]    ex_r, ey_r, ez_r;
  logic signed [31:0]    ox_r, oy_r, oz_r;

  function automatic ocep_pkg::fold_t fold(input logic [15:0] ang);
    ocep_pkg::fold_t  f;
    logic signed [16:0] a;
    a      = {ang[15], ang};
    f.flip = 1'b0;
    if (a > QTR) begin
      a      = a - HALF;
      f.flip = 1'b1;
    end else if (a < -QTR) begin
      a      = a + HALF;
      f.flip = 1'b1;
    end
    f.z = CW'($signed({a, 16'b0}));
    return f;
  endfunction

  function automatic ocep_pkg::cordic_t rot_step(input ocep_pkg::cordic_t c,
                                                 input logic [CNT_W-1:0] i,
                                                 input logic [31:0] at);
    ocep_pkg::cordic_t n;
    logic signed [CW-1:0] xs, ys, as;
    xs = c.x >>> i;
    ys = c.y >>> i;
    as = $signed({2'b00, at});
    if (!c.z[CW-1]) begin
      n.x = c.x - ys;
      n.y = c.y + xs;
      n.z = c.z - as;
    end else begin
      n.x = c.x + ys;
      n.y = c.y - xs;
      n.z = c.z + as;
    end
    return n;
  endfunction

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    if (v > SMAX) begin
      return 32'sh7FFFFFFF;
    end
    if (v < SMIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  assign pfold   = fold(q_data.polar);
  assign afold   = fold(q_data.azimuth);
  assign atn     = ocep_pkg::atan_turn32(5'(cnt_r));
  assign pc_step = rot_step(pc_r, cnt_r, atn);
  assign ac_step = rot_step(ac_r, cnt_r, atn);

  // angles past a quarter turn were folded, so negate both outputs
  assign st_w = pflip_r ? -pc_r.y : pc_r.y;
  assign ct_w = pflip_r ? -pc_r.x : pc_r.x;
  assign sp_w = aflip_r ? -ac_r.y : ac_r.y;
  assign cp_w = aflip_r ? -ac_r.x : ac_r.x;

  always_comb begin
    case (sel_r)
      ocep_pkg::MS_RSIN: begin
        mul_a = {r_r[31], r_r};
        mul_b = st_w[31:0];
      end
      ocep_pkg::MS_EYEY: begin
        mul_a = {r_r[31], r_r};
        mul_b = ct_w[31:0];
      end
      ocep_pkg::MS_EYEX: begin
        mul_a = rs_r;
        mul_b = cp_w[31:0];
      end
      ocep_pkg::MS_EYEZ: begin
        mul_a = rs_r;
        mul_b = sp_w[31:0];
      end
      default: begin
        mul_a = rs_r;
        mul_b = sp_w[31:0];
      end
    endcase
  end

  // round to nearest, halves up
  assign rnd_full = (prod_r + RND_HALF) >>> 30;
  assign rnd      = rnd_full[34:0];

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ocep_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = ocep_pkg::ST_ROT;
        end
      end
      ocep_pkg::ST_ROT: begin
        if (cnt_r == LAST_STEP) begin
          state_nxt = ocep_pkg::ST_MUL;
        end
      end
      ocep_pkg::ST_MUL: begin
        state_nxt = ocep_pkg::ST_ACC;
      end
      ocep_pkg::ST_ACC: begin
        state_nxt = (sel_r == ocep_pkg::MS_EYEZ) ? ocep_pkg::ST_DONE : ocep_pkg::ST_MUL;
      end
      ocep_pkg::ST_DONE: begin
        if (!out_valid_r || out_pop) begin
          load_out  = 1'b1;
          state_nxt = ocep_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ocep_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ocep_pkg::ST_IDLE;
      sel_r       <= ocep_pkg::MS_RSIN;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        cnt_r <= '0;
        sel_r <= ocep_pkg::MS_RSIN;
      end else if (state_r == ocep_pkg::ST_ROT) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (state_r == ocep_pkg::ST_ACC) begin
        case (sel_r)
          ocep_pkg::MS_RSIN: sel_r <= ocep_pkg::MS_EYEY;
          ocep_pkg::MS_EYEY: sel_r <= ocep_pkg::MS_EYEX;
          ocep_pkg::MS_EYEX: sel_r <= ocep_pkg::MS_EYEZ;
          default:           sel_r <= ocep_pkg::MS_RSIN;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      r_r     <= q_data.radius;
      cx_r    <= q_data.cx;
      cz_r    <= q_data.cz;
      pc_r.x  <= ocep_pkg::CORDIC_GAIN_Q30;
      pc_r.y  <= '0;
      pc_r.z  <= pfold.z;
      pflip_r <= pfold.flip;
      ac_r.x  <= ocep_pkg::CORDIC_GAIN_Q30;
      ac_r.y  <= '0;
      ac_r.z  <= afold.z;
      aflip_r <= afold.flip;
    end else if (state_r == ocep_pkg::ST_ROT) begin
      pc_r <= pc_step;
      ac_r <= ac_step;
    end
    if (state_r == ocep_pkg::ST_MUL) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == ocep_pkg::ST_ACC) begin
      case (sel_r)
        ocep_pkg::MS_RSIN: rs_r <= rnd[32:0];
        ocep_pkg::MS_EYEY: ey_r <= sat36({rnd[34], rnd});
        ocep_pkg::MS_EYEX: ex_r <= sat36({rnd[34], rnd} + {{4{cx_r[31]}}, cx_r});
        default:           ez_r <= sat36({rnd[34], rnd} + {{4{cz_r[31]}}, cz_r});
      endcase
    end
    if (load_out) begin
      ox_r <= ex_r;
      oy_r <= ey_r;
      oz_r <= ez_r;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_eye_x = ox_r;
  assign out_eye_y = oy_r;
  assign out_eye_z = oz_r;

endmodule

[rtl/core/orbit_camera_eye_position_top.sv]
`timescale 1ns / 1ps
// the back ends one word before it pops the next, set by the iterative cordic loop
//   and the one shared multiplier that forms the four products in turn
// the front takes up to two words ahead through a two-entry queue
// reset: synchronous active low, radius 30.0, both angles 45 degrees, center at zero

module orbit_camera_eye_position_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_req_type,
  input  logic signed [31:0] in_delta_radius,
  input  logic signed [15:0] in_delta_polar,
  input  logic signed [15:0] in_delta_azimuth,
  input  logic signed [31:0] in_delta_center_x,
  input  logic signed [31:0] in_delta_center_z,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_eye_x,
  output logic signed [31:0] out_eye_y,
  output logic signed [31:0] out_eye_z
);

  logic            q_push, q_full, q_pop, q_empty;
  ocep_pkg::snap_t q_wr, q_rd;

  ocep_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .q_full           (q_full),
    .in_req_type      (in_req_type),
    .in_delta_radius  (in_delta_radius),
    .in_delta_polar   (in_delta_polar),
    .in_delta_azimuth (in_delta_azimuth),
    .in_delta_center_x(in_delta_center_x),
    .in_delta_center_z(in_delta_center_z),
    .q_push           (q_push),
    .q_data           (q_wr)
  );

  ocep_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_data(q_wr),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_data(q_rd)
  );

  ocep_back #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rd),
    .q_pop    (q_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_eye_x(out_eye_x),
    .out_eye_y(out_eye_y),
    .out_eye_z(out_eye_z)
  );

  assign in_full = q_full;

endmodule

[rtl/core/ocep_checker.sv]
`timescale 1ns / 1ps
`include "orbit_camera_eye_position_top_assert.svh"

module ocep_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [31:0] out_eye_x,
  input logic signed [31:0] out_eye_y,
  input logic signed [31:0] out_eye_z
);

  // a waiting word holds until popped
  `OCEP_ASSERT_GATED(a_out_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_eye_x) && $stable(out_eye_y) && $stable(out_eye_z)), "result word changed before pop")

  `OCEP_ASSERT_RAW(a_rst_out, !rst_n |=> out_empty, "result queue not empty after reset")

  `OCEP_ASSERT_RAW(a_rst_in, !rst_n |=> !in_full, "input side full after reset")

  // the queue only fills on an accepted word
  `OCEP_ASSERT_GATED(a_full_rise, $rose(in_full) |-> $past(in_push && !in_full), "full rose without an accepted word")

endmodule

bind orbit_camera_eye_position_top ocep_checker u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_push  (in_push),
  .in_full  (in_full),
  .out_empty(out_empty),
  .out_pop  (out_pop),
  .out_eye_x(out_eye_x),
  .out_eye_y(out_eye_y),
  .out_eye_z(out_eye_z)
);
